// ===== hdl/ttps_pkg.sv =====
package ttps_pkg;

   // Default geometry of the table.
   localparam int CLUSTER_INDEX_BITS_DEF = 16;
   localparam int WAYS_DEF = 3;
   localparam int DEPTH_OFFSET_DEF = -3;

   // Field widths fixed by the interface.
   localparam int KEY_W = 64;
   localparam int TAG_W = 16;
   localparam int WAY_W = 2;
   localparam int VAL_W = 16;
   localparam int DEPTH_W = 8;
   localparam int BOUND_W = 2;
   localparam int AGE_W = 5;
   localparam int GEN_W = 8;

   // Age and replacement constants.
   localparam logic [7:0] AGE_MASK = 8'hF8;
   localparam logic [7:0] LOW_MASK = 8'h07;
   localparam int REPLACE_MARGIN = 4;
   localparam int PV_BONUS = 2;

   // Codes.
   localparam logic MODE_PROBE = 1'b0;
   localparam logic MODE_SAVE = 1'b1;
   localparam logic [1:0] EXACT_BOUND = 2'd3;

   // Register file.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_GENERATION = 1'b0;

   // One stored entry; age_bound is {age[4:0], pv, bound[1:0]}.
   typedef struct packed {
      logic [15:0] tag;
      logic [7:0]  depth;
      logic [7:0]  age_bound;
      logic [15:0] score;
      logic [15:0] eval;
      logic [15:0] move;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_wr;   // write a zero row at the clear pointer
      logic accept;     // capture the request beat and read its cluster
      logic eval_fire;  // write the updated cluster back
      logic load_rsp;   // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic is_probe;
   } sts_type;

   // Replacement worth of an entry: depth less the masked age distance.
   function automatic logic signed [9:0] repl_val(input entry_type e,
                                                  input logic [7:0] gen_bits);
      logic [7:0] diff;
      diff = (gen_bits - e.age_bound) & AGE_MASK;
      return $signed({{2{e.depth[7]}}, e.depth}) - $signed({2'b00, diff});
   endfunction

endpackage

// ===== hdl/transposition_table_probe_save.sv =====
// Clustered set-associative transposition table. Each request beat is a probe
// or a save against the cluster picked by the low CLUSTER_INDEX_BITS bits of
// the position key, tagged by the low 16 key bits. A probe returns exactly one
// response beat describing the matched, empty or replacement way and refreshes
// the age of a matched or empty way; a save returns nothing. Each item first
// reads its cluster row from the table memory, which has separate read and
// write ports, then compares the ways and writes the row back. A probe waits
// in that compare step while the previous response beat is still stalled. After
// reset the table is zero-filled one cluster per cycle, 2**CLUSTER_INDEX_BITS
// clusters (65536 with the default geometry), and req_stall stays high during
// that pass; the search_generation register may still be written meanwhile.
// Software writes search_generation only while the block is idle.
module transposition_table_probe_save #(
   parameter int CLUSTER_INDEX_BITS = ttps_pkg::CLUSTER_INDEX_BITS_DEF,
   parameter int WAYS = ttps_pkg::WAYS_DEF,
   parameter int DEPTH_OFFSET = ttps_pkg::DEPTH_OFFSET_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   // Request channel.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_mode,
   input  logic [63:0]                         req_position_key,
   input  logic [1:0]                          req_target_way,
   input  logic signed [15:0]                  req_score_value,
   input  logic signed [15:0]                  req_static_eval,
   input  logic signed [7:0]                   req_search_depth,
   input  logic                                req_is_pv,
   input  logic [1:0]                          req_bound_kind,
   input  logic [15:0]                         req_best_move,

   // Response channel.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic [1:0]                          rsp_chosen_way,
   output logic signed [7:0]                   rsp_stored_depth,
   output logic [1:0]                          rsp_stored_bound,
   output logic                                rsp_stored_pv,
   output logic [4:0]                          rsp_stored_age,
   output logic signed [15:0]                  rsp_stored_score,
   output logic signed [15:0]                  rsp_stored_eval,
   output logic [15:0]                         rsp_stored_move,

   // Configuration port.
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ttps_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ttps_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ttps_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   // The only register is search_generation at word zero. Only its upper five
   // bits reach the age logic; the full byte is kept so reads return it.
   logic [7:0] generation_ff;
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == ttps_pkg::CSR_IDX_GENERATION);

   always_ff @(posedge clock) begin
      if (reset) begin
         generation_ff <= '0;
      end else if (csr_wr) begin
         generation_ff <= csr_pwdata[7:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == ttps_pkg::CSR_IDX_GENERATION) begin
         csr_prdata = {{(ttps_pkg::CSR_DATA_W - 8){1'b0}}, generation_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   // The controller sequences clear, read and write-back; the datapath holds
   // the captured beat, the table memory and the response register.
   ttps_pkg::cmd_type dp_cmd;
   ttps_pkg::sts_type dp_sts;

   ttps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (dp_sts),
      .cmd       (dp_cmd)
   );

   ttps_dpath #(
      .CLUSTER_INDEX_BITS (CLUSTER_INDEX_BITS),
      .WAYS               (WAYS),
      .DEPTH_OFFSET       (DEPTH_OFFSET)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (dp_cmd),
      .sts               (dp_sts),
      .search_generation (generation_ff),
      .req_mode          (req_mode),
      .req_position_key  (req_position_key),
      .req_target_way    (req_target_way),
      .req_score_value   (req_score_value),
      .req_static_eval   (req_static_eval),
      .req_search_depth  (req_search_depth),
      .req_is_pv         (req_is_pv),
      .req_bound_kind    (req_bound_kind),
      .req_best_move     (req_best_move),
      .rsp_hit           (rsp_hit),
      .rsp_chosen_way    (rsp_chosen_way),
      .rsp_stored_depth  (rsp_stored_depth),
      .rsp_stored_bound  (rsp_stored_bound),
      .rsp_stored_pv     (rsp_stored_pv),
      .rsp_stored_age    (rsp_stored_age),
      .rsp_stored_score  (rsp_stored_score),
      .rsp_stored_eval   (rsp_stored_eval),
      .rsp_stored_move   (rsp_stored_move)
   );

   // An accepted beat is always followed by its evaluation cycle, never by a
   // second accept, so the memory read data cannot be overtaken.
   a_accept_spacing: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.accept |=> !dp_cmd.accept)
      else $error("request accepted in the evaluation cycle");

   // A new response only loads when the previous one has left or is leaving.
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load_rsp |-> (!rsp_valid || !rsp_stall))
      else $error("response register overwritten while stalled");

   // No request is taken while the zero fill is still running.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.clear_wr |-> (req_stall && !dp_cmd.accept && !dp_cmd.eval_fire))
      else $error("request activity during the clearing pass");

endmodule

// ===== hdl/ttps_ram.sv =====
module ttps_ram #(
   parameter int WIDTH = ttps_pkg::ENTRY_W * ttps_pkg::WAYS_DEF,
   parameter int DEPTH = 2 ** ttps_pkg::CLUSTER_INDEX_BITS_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ttps_ctrl.sv =====
module ttps_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  ttps_pkg::sts_type   sts,
   output ttps_pkg::cmd_type   cmd
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EVAL  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;
   logic       fire;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign fire = (state_ff == ST_EVAL) && (!sts.is_probe || slot_free);

   always_comb begin
      cmd.clear_wr  = (state_ff == ST_CLEAR);
      cmd.accept    = (state_ff == ST_IDLE) && req_valid;
      cmd.eval_fire = fire;
      cmd.load_rsp  = fire && sts.is_probe;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (fire) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/ttps_dpath.sv =====
module ttps_dpath #(
   parameter int CLUSTER_INDEX_BITS = ttps_pkg::CLUSTER_INDEX_BITS_DEF,
   parameter int WAYS = ttps_pkg::WAYS_DEF,
   parameter int DEPTH_OFFSET = ttps_pkg::DEPTH_OFFSET_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ttps_pkg::cmd_type   cmd,
   output ttps_pkg::sts_type   sts,
   input  logic [7:0]          search_generation,
   input  logic                req_mode,
   input  logic [63:0]         req_position_key,
   input  logic [1:0]          req_target_way,
   input  logic signed [15:0]  req_score_value,
   input  logic signed [15:0]  req_static_eval,
   input  logic signed [7:0]   req_search_depth,
   input  logic                req_is_pv,
   input  logic [1:0]          req_bound_kind,
   input  logic [15:0]         req_best_move,
   output logic                rsp_hit,
   output logic [1:0]          rsp_chosen_way,
   output logic signed [7:0]   rsp_stored_depth,
   output logic [1:0]          rsp_stored_bound,
   output logic                rsp_stored_pv,
   output logic [4:0]          rsp_stored_age,
   output logic signed [15:0]  rsp_stored_score,
   output logic signed [15:0]  rsp_stored_eval,
   output logic [15:0]         rsp_stored_move
);

   localparam int ROW_W = WAYS * ttps_pkg::ENTRY_W;
   localparam int NUM_ROWS = 2 ** CLUSTER_INDEX_BITS;
   localparam logic signed [9:0] DEPTH_OFF_10 = 10'(DEPTH_OFFSET);
   localparam logic signed [9:0] MARGIN_10 = 10'(ttps_pkg::REPLACE_MARGIN);
   localparam logic signed [9:0] PV_BONUS_10 = 10'(ttps_pkg::PV_BONUS);

   // Captured request beat.
   logic                          mode_ff;
   logic [CLUSTER_INDEX_BITS-1:0] index_ff;
   logic [15:0]                   tag_ff;
   logic [1:0]                    way_ff;
   logic [15:0]                   score_ff;
   logic [15:0]                   eval_ff;
   logic [7:0]                    depth_ff;
   logic                          pv_ff;
   logic [1:0]                    bound_ff;
   logic [15:0]                   move_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff  <= req_mode;
         index_ff <= req_position_key[CLUSTER_INDEX_BITS-1:0];
         tag_ff   <= req_position_key[15:0];
         way_ff   <= req_target_way;
         score_ff <= req_score_value;
         eval_ff  <= req_static_eval;
         depth_ff <= req_search_depth;
         pv_ff    <= req_is_pv;
         bound_ff <= req_bound_kind;
         move_ff  <= req_best_move;
      end
   end

   // Clear pointer for the zero fill after reset.
   logic [CLUSTER_INDEX_BITS-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   assign sts.clear_last = &clr_addr_ff;
   assign sts.is_probe = (mode_ff == ttps_pkg::MODE_PROBE);

   // Cluster memory, one row per cluster.
   logic [ROW_W-1:0]                   rd_data;
   logic [ROW_W-1:0]                   wr_data;
   logic [CLUSTER_INDEX_BITS-1:0]      wr_addr;
   ttps_pkg::entry_type [WAYS-1:0]     row_rd;
   ttps_pkg::entry_type [WAYS-1:0]     row_wr;

   assign row_rd  = rd_data;
   assign wr_addr = cmd.clear_wr ? clr_addr_ff : index_ff;
   assign wr_data = cmd.clear_wr ? '0 : row_wr;

   ttps_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_ROWS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.clear_wr | cmd.eval_fire),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (req_position_key[CLUSTER_INDEX_BITS-1:0]),
      .rd_data (rd_data)
   );

   logic [7:0] gen_bits;
   assign gen_bits = search_generation & ttps_pkg::AGE_MASK;

   // Probe: first matching or empty way, else the cheapest way to replace.
   logic                 found;
   logic [1:0]           take_way;
   logic [1:0]           best_way;
   logic signed [9:0]    best_val;
   logic signed [9:0]    cand_val;
   logic [1:0]           chosen_way;
   ttps_pkg::entry_type  sel;
   logic [7:0]           sel_age_bound;
   logic                 hit;

   always_comb begin
      found    = 1'b0;
      take_way = '0;
      best_way = '0;
      best_val = ttps_pkg::repl_val(row_rd[0], gen_bits);
      cand_val = best_val;
      for (int w = 0; w < WAYS; w++) begin
         if (!found && (row_rd[w].tag == tag_ff || row_rd[w].depth == 8'd0)) begin
            found    = 1'b1;
            take_way = 2'(w);
         end
      end
      for (int w = 1; w < WAYS; w++) begin
         cand_val = ttps_pkg::repl_val(row_rd[w], gen_bits);
         if (best_val > cand_val) begin
            best_val = cand_val;
            best_way = 2'(w);
         end
      end
   end

   always_comb begin
      chosen_way = found ? take_way : best_way;
      sel = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (chosen_way == 2'(w)) sel = row_rd[w];
      end
      sel_age_bound = found ? (gen_bits | (sel.age_bound & ttps_pkg::LOW_MASK))
                            : sel.age_bound;
      hit = found && (sel.depth != 8'd0) && (sel.tag == tag_ff);
   end

   // Save decision and the row written back.
   ttps_pkg::entry_type  old;
   ttps_pkg::entry_type  upd;
   logic                 tag_differs;
   logic signed [9:0]    new_depth;
   logic signed [9:0]    new_worth;
   logic signed [9:0]    old_worth;
   logic                 overwrite;

   always_comb begin
      old = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (way_ff == 2'(w)) old = row_rd[w];
      end
      tag_differs = (old.tag != tag_ff);
      new_depth   = $signed({{2{depth_ff[7]}}, depth_ff}) - DEPTH_OFF_10;
      new_worth   = new_depth + (pv_ff ? PV_BONUS_10 : 10'sd0);
      old_worth   = $signed({{2{old.depth[7]}}, old.depth}) - MARGIN_10;
      overwrite   = (bound_ff == ttps_pkg::EXACT_BOUND) || tag_differs ||
                    (new_worth > old_worth);
      upd = old;
      if (move_ff != 16'd0 || tag_differs) begin
         upd.move = move_ff;
      end
      if (overwrite) begin
         upd.tag       = tag_ff;
         upd.depth     = new_depth[7:0];
         upd.age_bound = gen_bits | {5'b00000, pv_ff, bound_ff};
         upd.score     = score_ff;
         upd.eval      = eval_ff;
      end

      row_wr = row_rd;
      for (int w = 0; w < WAYS; w++) begin
         if (mode_ff == ttps_pkg::MODE_SAVE) begin
            if (way_ff == 2'(w)) row_wr[w] = upd;
         end else if (found && take_way == 2'(w)) begin
            row_wr[w].age_bound = gen_bits | (row_rd[w].age_bound & ttps_pkg::LOW_MASK);
         end
      end
   end

   // Result register.
   logic        hit_ff;
   logic [1:0]  chosen_way_ff;
   logic [7:0]  st_depth_ff;
   logic [7:0]  st_age_bound_ff;
   logic [15:0] st_score_ff;
   logic [15:0] st_eval_ff;
   logic [15:0] st_move_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         hit_ff          <= hit;
         chosen_way_ff   <= chosen_way;
         st_depth_ff     <= sel.depth;
         st_age_bound_ff <= sel_age_bound;
         st_score_ff     <= sel.score;
         st_eval_ff      <= sel.eval;
         st_move_ff      <= sel.move;
      end
   end

   assign rsp_hit          = hit_ff;
   assign rsp_chosen_way   = chosen_way_ff;
   assign rsp_stored_depth = st_depth_ff;
   assign rsp_stored_bound = st_age_bound_ff[1:0];
   assign rsp_stored_pv    = st_age_bound_ff[2];
   assign rsp_stored_age   = st_age_bound_ff[7:3];
   assign rsp_stored_score = st_score_ff;
   assign rsp_stored_eval  = st_eval_ff;
   assign rsp_stored_move  = st_move_ff;

endmodule

// ===== tb/transposition_table_probe_save_checker.sv =====
module tt_probe_save_checker #(
   parameter int CLUSTER_INDEX_BITS = ttps_pkg::CLUSTER_INDEX_BITS_DEF,
   parameter int WAYS = ttps_pkg::WAYS_DEF,
   parameter int DEPTH_OFFSET = ttps_pkg::DEPTH_OFFSET_DEF
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_mode,
   input  logic [63:0]                     req_position_key,
   input  logic [1:0]                      req_target_way,
   input  logic signed [15:0]              req_score_value,
   input  logic signed [15:0]              req_static_eval,
   input  logic signed [7:0]               req_search_depth,
   input  logic                            req_is_pv,
   input  logic [1:0]                      req_bound_kind,
   input  logic [15:0]                     req_best_move,

   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_hit,
   input  logic [1:0]                      rsp_chosen_way,
   input  logic signed [7:0]               rsp_stored_depth,
   input  logic [1:0]                      rsp_stored_bound,
   input  logic                            rsp_stored_pv,
   input  logic [4:0]                      rsp_stored_age,
   input  logic signed [15:0]              rsp_stored_score,
   input  logic signed [15:0]              rsp_stored_eval,
   input  logic [15:0]                     rsp_stored_move,

   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ttps_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ttps_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                            csr_pready,

   output int                              fail_count,
   output int                              pending_count,
   output int                              answers_seen,
   output int                              hits_seen
);

   localparam int SLOTS = (1 << CLUSTER_INDEX_BITS) * WAYS;
   localparam int ADDR_W = ttps_pkg::CSR_ADDR_W;
   localparam logic [ADDR_W-1:0] GEN_ADDR = ADDR_W'(4 * ttps_pkg::CSR_IDX_GENERATION);

   typedef struct packed {
      logic [15:0] tag;
      logic [7:0]  depth;
      logic [7:0]  age_bound;
      logic [15:0] score;
      logic [15:0] eval;
      logic [15:0] move;
   } slot_type;

   typedef struct packed {
      logic        hit;
      logic [1:0]  way;
      logic [7:0]  depth;
      logic [1:0]  bound;
      logic        pv;
      logic [4:0]  age;
      logic [15:0] score;
      logic [15:0] eval;
      logic [15:0] move;
   } probe_answer_type;

   slot_type         slot_mem [SLOTS];
   logic [7:0]       generation;
   probe_answer_type answers_q [$];
   int               fail_total;
   int               answer_total;
   int               hit_total;

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         slot_mem[i] = '0;
      end
      generation = '0;
      fail_total = 0;
      answer_total = 0;
      hit_total = 0;
   end

   function automatic logic [7:0] age_now();
      return generation & ttps_pkg::AGE_MASK;
   endfunction

   // How much a way is worth keeping: its depth less the aged-out distance.
   function automatic int keep_worth(slot_type s);
      logic [7:0] gap;
      gap = (age_now() - s.age_bound) & ttps_pkg::AGE_MASK;
      return int'($signed(s.depth)) - int'(gap);
   endfunction

   function automatic probe_answer_type probe_cluster(logic [63:0] key);
      int               base;
      int               way;
      int               w;
      bit               found;
      logic [15:0]      tag;
      slot_type         s;
      probe_answer_type a;
      base = int'(key[CLUSTER_INDEX_BITS-1:0]) * WAYS;
      tag = key[15:0];
      way = 0;
      found = 1'b0;
      a = '0;
      for (w = 0; w < WAYS; w++) begin
         if (!found && (slot_mem[base+w].tag == tag || slot_mem[base+w].depth == 8'd0)) begin
            slot_mem[base+w].age_bound =
               age_now() | (slot_mem[base+w].age_bound & ttps_pkg::LOW_MASK);
            a.hit = slot_mem[base+w].depth != 8'd0 && slot_mem[base+w].tag == tag;
            way = w;
            found = 1'b1;
         end
      end
      if (!found) begin
         for (w = 1; w < WAYS; w++) begin
            if (keep_worth(slot_mem[base+way]) > keep_worth(slot_mem[base+w])) begin
               way = w;
            end
         end
      end
      s = slot_mem[base+way];
      a.way = 2'(way);
      a.depth = s.depth;
      a.bound = s.age_bound[1:0];
      a.pv = s.age_bound[2];
      a.age = s.age_bound[7:3];
      a.score = s.score;
      a.eval = s.eval;
      a.move = s.move;
      return a;
   endfunction

   function automatic void save_entry(logic [63:0] key, logic [1:0] target,
                                      logic [15:0] score, logic [15:0] eval,
                                      logic signed [7:0] depth, logic pv,
                                      logic [1:0] bound, logic [15:0] move);
      int       idx;
      int       new_depth;
      bit       tag_moved;
      slot_type s;
      if (int'(target) >= WAYS) begin
         return;
      end
      idx = int'(key[CLUSTER_INDEX_BITS-1:0]) * WAYS + int'(target);
      s = slot_mem[idx];
      tag_moved = s.tag != key[15:0];
      new_depth = int'(depth) - DEPTH_OFFSET;
      if (move != 16'd0 || tag_moved) begin
         s.move = move;
      end
      if (bound == ttps_pkg::EXACT_BOUND || tag_moved ||
          new_depth + ttps_pkg::PV_BONUS * int'(pv) >
             int'($signed(s.depth)) - ttps_pkg::REPLACE_MARGIN) begin
         s.tag = key[15:0];
         s.depth = 8'(new_depth);
         s.age_bound = age_now() | {5'd0, pv, bound};
         s.score = score;
         s.eval = eval;
      end
      slot_mem[idx] = s;
   endfunction

   function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         fail_total++;
      end
   endfunction

   always @(posedge clock) begin : watch
      probe_answer_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            answer_total++;
            if (rsp_hit) begin
               hit_total++;
            end
            if (answers_q.size() == 0) begin
               $display("%0t: response beat with no probe waiting", $time);
               fail_total++;
            end else begin
               want = answers_q.pop_front();
               compare_field("hit", want.hit, rsp_hit);
               compare_field("chosen_way", want.way, rsp_chosen_way);
               compare_field("stored_depth", want.depth, $unsigned(rsp_stored_depth));
               compare_field("stored_bound", want.bound, rsp_stored_bound);
               compare_field("stored_pv", want.pv, rsp_stored_pv);
               compare_field("stored_age", want.age, rsp_stored_age);
               compare_field("stored_score", want.score, $unsigned(rsp_stored_score));
               compare_field("stored_eval", want.eval, $unsigned(rsp_stored_eval));
               compare_field("stored_move", want.move, rsp_stored_move);
            end
         end
         if (req_valid && !req_stall) begin
            if (req_mode == ttps_pkg::MODE_PROBE) begin
               answers_q.push_back(probe_cluster(req_position_key));
            end else begin
               save_entry(req_position_key, req_target_way, req_score_value, req_static_eval,
                          req_search_depth, req_is_pv, req_bound_kind, req_best_move);
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == GEN_ADDR) begin
            generation = csr_pwdata[7:0];
         end
      end
      fail_count <= fail_total;
      pending_count <= answers_q.size();
      answers_seen <= answer_total;
      hits_seen <= hit_total;
   end

endmodule

// ===== tb/tb_transposition_table_probe_save.sv =====
module tb_transposition_table_probe_save;

   // The longest stretch without any beat is the zero-fill pass after reset,
   // one cluster per cycle; the limit leaves several times that.
   localparam int WATCHDOG_LIMIT = 300000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASES = 8;
   localparam int BEATS_PER_PHASE = 210;
   localparam int POOL_SIZE = 10;
   localparam int SETTLE_CYCLES = 8;

   localparam int ADDR_W = ttps_pkg::CSR_ADDR_W;
   localparam int DATA_W = ttps_pkg::CSR_DATA_W;
   localparam logic [ADDR_W-1:0] GEN_ADDR = ADDR_W'(4 * ttps_pkg::CSR_IDX_GENERATION);
   localparam logic [1:0] BOUND_NONE = 2'd0;
   localparam logic [1:0] BOUND_UPPER = 2'd1;
   localparam logic [1:0] BOUND_LOWER = 2'd2;
   localparam logic [15:0] NO_MOVE = 16'd0;

   typedef struct packed {
      logic        mode;
      logic [63:0] key;
      logic [1:0]  way;
      logic [15:0] score;
      logic [15:0] eval;
      logic [7:0]  depth;
      logic        pv;
      logic [1:0]  bound;
      logic [15:0] move;
   } beat_type;

   logic                  clock = 1'b0;
   logic                  reset;

   logic                  req_valid;
   logic                  req_stall;
   logic                  req_mode;
   logic [63:0]           req_position_key;
   logic [1:0]            req_target_way;
   logic signed [15:0]    req_score_value;
   logic signed [15:0]    req_static_eval;
   logic signed [7:0]     req_search_depth;
   logic                  req_is_pv;
   logic [1:0]            req_bound_kind;
   logic [15:0]           req_best_move;

   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_hit;
   logic [1:0]            rsp_chosen_way;
   logic signed [7:0]     rsp_stored_depth;
   logic [1:0]            rsp_stored_bound;
   logic                  rsp_stored_pv;
   logic [4:0]            rsp_stored_age;
   logic signed [15:0]    rsp_stored_score;
   logic signed [15:0]    rsp_stored_eval;
   logic [15:0]           rsp_stored_move;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [ADDR_W-1:0]     csr_paddr;
   logic [DATA_W-1:0]     csr_pwdata;
   logic [DATA_W-1:0]     csr_prdata;
   logic                  csr_pready;

   int                    fail_count;
   int                    pending_count;
   int                    answers_seen;
   int                    hits_seen;

   // Request beats accepted so far; it paces the calm window and the hold-off.
   int                    items_accepted = 0;
   int                    quiet_cycles = 0;
   logic [15:0]           cluster_pool [POOL_SIZE];
   logic                  calm;

   // A window in the middle of the run where neither side idles, so the block
   // is driven back to back at its full rate.
   assign calm = items_accepted >= 900 && items_accepted < 1150;

   always #10 clock = ~clock;

   transposition_table_probe_save dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_position_key (req_position_key),
      .req_target_way   (req_target_way),
      .req_score_value  (req_score_value),
      .req_static_eval  (req_static_eval),
      .req_search_depth (req_search_depth),
      .req_is_pv        (req_is_pv),
      .req_bound_kind   (req_bound_kind),
      .req_best_move    (req_best_move),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_chosen_way   (rsp_chosen_way),
      .rsp_stored_depth (rsp_stored_depth),
      .rsp_stored_bound (rsp_stored_bound),
      .rsp_stored_pv    (rsp_stored_pv),
      .rsp_stored_age   (rsp_stored_age),
      .rsp_stored_score (rsp_stored_score),
      .rsp_stored_eval  (rsp_stored_eval),
      .rsp_stored_move  (rsp_stored_move),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   tt_probe_save_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_position_key (req_position_key),
      .req_target_way   (req_target_way),
      .req_score_value  (req_score_value),
      .req_static_eval  (req_static_eval),
      .req_search_depth (req_search_depth),
      .req_is_pv        (req_is_pv),
      .req_bound_kind   (req_bound_kind),
      .req_best_move    (req_best_move),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_chosen_way   (rsp_chosen_way),
      .rsp_stored_depth (rsp_stored_depth),
      .rsp_stored_bound (rsp_stored_bound),
      .rsp_stored_pv    (rsp_stored_pv),
      .rsp_stored_age   (rsp_stored_age),
      .rsp_stored_score (rsp_stored_score),
      .rsp_stored_eval  (rsp_stored_eval),
      .rsp_stored_move  (rsp_stored_move),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_pready       (csr_pready),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .answers_seen     (answers_seen),
      .hits_seen        (hits_seen)
   );

   function automatic beat_type probe_beat(logic [63:0] key);
      beat_type b;
      b = '0;
      b.mode = ttps_pkg::MODE_PROBE;
      b.key = key;
      return b;
   endfunction

   function automatic beat_type save_beat(logic [63:0] key, logic [1:0] way, int depth,
                                          logic pv, logic [1:0] bound, int score, int eval,
                                          logic [15:0] move);
      beat_type b;
      b.mode = ttps_pkg::MODE_SAVE;
      b.key = key;
      b.way = way;
      b.depth = 8'(depth);
      b.pv = pv;
      b.bound = bound;
      b.score = 16'(score);
      b.eval = 16'(eval);
      b.move = move;
      return b;
   endfunction

   // Most keys land in a handful of clusters so that saves and probes meet the
   // same entries again and again; a few keys are fully random. The upper key
   // bits are always random, since only the low bits select and tag an entry.
   function automatic beat_type random_beat();
      beat_type    b;
      logic [15:0] cl;
      cl = cluster_pool[$urandom_range(0, POOL_SIZE - 1)];
      b.mode = ($urandom_range(0, 1) == 1) ? ttps_pkg::MODE_SAVE : ttps_pkg::MODE_PROBE;
      if ($urandom_range(0, 9) == 0) begin
         b.key = {$urandom(), $urandom()};
      end else begin
         b.key = {$urandom(), 16'($urandom()), cl};
      end
      // Way three does not exist; a save aimed at it must leave the table alone.
      b.way = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      b.score = 16'($urandom());
      b.eval = 16'($urandom());
      // Mostly legal search depths, sometimes any byte so the stored depth wraps
      // or lands on zero and empties the entry.
      if ($urandom_range(0, 9) == 0) begin
         b.depth = 8'($urandom());
      end else begin
         b.depth = 8'($urandom_range(0, 126) - 2);
      end
      b.pv = 1'($urandom());
      b.bound = 2'($urandom());
      b.move = ($urandom_range(0, 3) == 0) ? NO_MOVE : 16'($urandom());
      return b;
   endfunction

   // Presents one beat and returns at the clock edge that accepts it. The
   // sender sometimes idles first; valid never looks at stall.
   task automatic offer_beat(input beat_type b);
      if (!calm && $urandom_range(0, 99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= b.mode;
      req_position_key <= b.key;
      req_target_way <= b.way;
      req_score_value <= b.score;
      req_static_eval <= b.eval;
      req_search_depth <= b.depth;
      req_is_pv <= b.pv;
      req_bound_kind <= b.bound;
      req_best_move <= b.move;
      do @(posedge clock); while (req_stall);
      items_accepted <= items_accepted + 1;
   endtask

   // Stops offering, waits for every predicted response beat, then waits out the
   // settle time so that a trailing save can finish its write-back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One write transfer: a setup phase, then an access phase until pready.
   task automatic write_generation(input logic [7:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= GEN_ADDR;
      csr_pwdata <= {24'($urandom()), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   initial begin : stimulus
      logic [7:0]  gen_plan [PHASES];
      logic [63:0] key_mid;
      logic [63:0] key_mid_alias;
      logic [63:0] key_zero;
      logic [63:0] key_ones;
      int          phase;
      int          n;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= ttps_pkg::MODE_PROBE;
      req_position_key <= '0;
      req_target_way <= '0;
      req_score_value <= '0;
      req_static_eval <= '0;
      req_search_depth <= '0;
      req_is_pv <= 1'b0;
      req_bound_kind <= BOUND_NONE;
      req_best_move <= NO_MOVE;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;

      // The pool always holds the lowest and highest cluster and the one the
      // directed part uses; the rest are picked at random.
      cluster_pool[0] = 16'h0000;
      cluster_pool[1] = 16'hFFFF;
      cluster_pool[2] = 16'h0005;
      for (n = 3; n < POOL_SIZE; n++) begin
         cluster_pool[n] = 16'($urandom());
      end

      // Generation settings per random phase: the top value, one whose only
      // set bits are the ignored low ones, all ones, zero, the single top bit
      // and a few random values.
      gen_plan[0] = 8'hF8;
      gen_plan[1] = 8'h07;
      gen_plan[2] = 8'hFF;
      gen_plan[3] = 8'($urandom());
      gen_plan[4] = 8'h00;
      gen_plan[5] = 8'($urandom());
      gen_plan[6] = 8'h80;
      gen_plan[7] = 8'($urandom());

      key_mid = 64'hDEAD_BEEF_0000_0005;
      key_mid_alias = 64'h0123_4567_89AB_0005;
      key_zero = 64'hFFFF_FFFF_FFFF_0000;
      key_ones = 64'hFFFF_FFFF_FFFF_FFFF;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part, run at the reset generation. The table is still busy
      // clearing itself, so the first beat waits out that pass.
      offer_beat(probe_beat(key_mid));
      offer_beat(save_beat(key_mid, 2'd0, 124, 1'b1, ttps_pkg::EXACT_BOUND, 32767, -32768,
                           16'hFFFF));
      // Same low bits with different upper bits must hit the same entry.
      offer_beat(probe_beat(key_mid_alias));
      offer_beat(save_beat(key_mid, 2'd1, -2, 1'b0, BOUND_UPPER, -32768, 32767, NO_MOVE));
      // A depth of minus three stores a zero byte, which leaves the way empty.
      offer_beat(save_beat(key_mid, 2'd2, -3, 1'b0, BOUND_LOWER, 100, -100, 16'h1234));
      offer_beat(probe_beat(key_mid));
      // A save aimed past the last way is dropped.
      offer_beat(save_beat(key_mid, 2'd3, 40, 1'b1, ttps_pkg::EXACT_BOUND, 7, 7, 16'h4321));
      // Shallow, inexact and moveless on a matching tag: nothing changes.
      offer_beat(save_beat(key_mid, 2'd0, 5, 1'b0, BOUND_NONE, 1, 2, NO_MOVE));
      offer_beat(probe_beat(key_mid));
      // The largest depth wraps the stored byte into the negative range.
      offer_beat(save_beat(key_mid, 2'd0, 127, 1'b0, ttps_pkg::EXACT_BOUND, 11, -11,
                           16'h8000));
      offer_beat(probe_beat(key_mid));
      offer_beat(save_beat(key_mid, 2'd0, -128, 1'b1, BOUND_UPPER, -1, 1, 16'h0001));
      offer_beat(probe_beat(key_mid));
      // Cluster zero: the reset tag already matches the key.
      offer_beat(probe_beat(key_zero));
      offer_beat(save_beat(key_zero, 2'd1, 60, 1'b1, BOUND_LOWER, 300, -300, NO_MOVE));
      offer_beat(probe_beat(key_zero));
      // Top cluster: tags differ from the reset value, so the first save to each way overwrites.
      offer_beat(probe_beat(key_ones));
      offer_beat(save_beat(key_ones, 2'd2, 0, 1'b0, BOUND_NONE, 0, 0, NO_MOVE));
      offer_beat(probe_beat(key_ones));
      offer_beat(save_beat(key_ones, 2'd0, 50, 1'b1, ttps_pkg::EXACT_BOUND, -5000, 5000,
                           16'hBEEF));
      offer_beat(probe_beat(key_ones));
      offer_beat(save_beat(key_ones, 2'd0, -1, 1'b0, BOUND_NONE, 9, 9, NO_MOVE));
      offer_beat(probe_beat(key_ones));

      // Random phases, each under its own generation, written while idle.
      for (phase = 0; phase < PHASES; phase++) begin
         drain();
         write_generation(gen_plan[phase]);
         for (n = 0; n < BEATS_PER_PHASE; n++) begin
            offer_beat(random_beat());
         end
      end

      drain();
      $display("Ran %0d request beats over %0d generation settings; %0d probe responses, %0d hits.",
               items_accepted, PHASES + 1, answers_seen, hits_seen);
      $display("Included a %0d-cycle response hold-off and a window of back-to-back traffic.",
               HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Receiver: random stalls, none in the calm window, and one long hold-off
   // while the sender keeps offering, so the block backs up and raises
   // req_stall.
   initial begin : receiver
      bit held;
      held = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && items_accepted >= 400) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= !calm && $urandom_range(0, 99) < 6;
         end
      end
   end

   // Watchdog: any beat on either channel or a register transfer counts as
   // progress; a long stretch without one ends the run as a failure.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d cycles without progress at %0t", quiet_cycles, $time);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule
